// File: sv/rssg_pkg.sv
// Package for the RTC slot snapshot gate: payload structs, opcodes, action codes,
// controller commands and status.
// No dependencies.
package rssg_pkg;

    localparam logic [31:0] NO_SLOT      = 32'hFFFF_FFFF;
    localparam logic [15:0] IV_DEFAULT   = 16'd60;
    localparam logic [15:0] YEAR_DAYS    = 16'd372;
    localparam logic [15:0] MONTH_DAYS   = 16'd31;
    localparam logic [31:0] DAY_SECONDS  = 32'd86400;
    localparam logic [16:0] HOUR_SECONDS = 17'd3600;
    localparam logic [16:0] MIN_SECONDS  = 17'd60;
    localparam int          QUO_W        = 32;
    localparam int          CNT_W        = $clog2(QUO_W);

    typedef enum logic [1:0] {
        OP_POLL   = 2'd0,
        OP_MARK   = 2'd1,
        OP_LIGHT  = 2'd2,
        OP_RESYNC = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_SEND        = 4'd1,
        ACT_RESTART     = 4'd2,
        ACT_SKIP_LIGHT  = 4'd3,
        ACT_SKIP_SENT   = 4'd4,
        ACT_HOLD        = 4'd5,
        ACT_SAME_SLOT   = 4'd6,
        ACT_GATED       = 4'd7,
        ACT_CLK_INVALID = 4'd8,
        ACT_WAIT_FRAME  = 4'd9,
        ACT_RECORDED    = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        REG_GATE_ENABLE = 2'd0,
        REG_INTERVAL    = 2'd1,
        REG_HOLD_MS     = 2'd2,
        REG_SKIP_MS     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [31:0] last_control_ms;
        logic        clock_valid;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [1:0]  sampler_status;
        logic        provisioned;
    } in_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] slot_value;
    } out_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: sv/rssg_datapath.sv
// Datapath of the RTC slot snapshot gate: item capture, slot arithmetic, serial
// divider, gate state, configuration registers and output register.
// Depends on rssg_pkg.
module rssg_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata,
    input  rssg_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rssg_pkg::out_t    m_data,
    input  rssg_pkg::cmd_t    cmd,
    output rssg_pkg::status_t status
);

    rssg_pkg::in_t  item_reg;
    rssg_pkg::out_t out_reg;
    logic           m_valid_reg, m_valid_next;

    logic        gate_en_reg;
    logic [15:0] iv_reg;
    logic [31:0] hold_ms_reg, skip_ms_reg;

    logic [31:0] handled_reg, handled_next;
    logic [31:0] sent_reg, sent_next;
    logic [31:0] light_tick_reg, light_tick_next;
    logic        skip_pend_reg, skip_pend_next;

    logic [rssg_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [15:0]                rem_reg, rem_next;
    logic [rssg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       hold_reg, skip_hit_reg;

    logic [15:0] key;
    logic [16:0] sod;
    logic [31:0] dividend;
    logic [16:0] shifted;
    logic        ge;
    logic        slot_ok;
    logic [31:0] hold_diff, skip_diff;

    rssg_pkg::action_t act;
    logic [31:0]       report;

    assign key = 16'(item_reg.year) * rssg_pkg::YEAR_DAYS
               + 16'(item_reg.month) * rssg_pkg::MONTH_DAYS
               + 16'(item_reg.day_of_month);
    assign sod = 17'(item_reg.hours) * rssg_pkg::HOUR_SECONDS
               + 17'(item_reg.minutes) * rssg_pkg::MIN_SECONDS
               + 17'(item_reg.seconds);
    // Fits in 32 bits for every field pattern: largest key times a day plus the largest second count.
    assign dividend = 32'(key) * rssg_pkg::DAY_SECONDS + 32'(sod);

    assign slot_ok = item_reg.clock_valid && (item_reg.hours <= 5'd23)
                   && (item_reg.minutes <= 6'd59) && (item_reg.seconds <= 6'd59);

    assign hold_diff = item_reg.now_ms - item_reg.last_control_ms;
    assign skip_diff = item_reg.now_ms - light_tick_reg;

    assign shifted = {rem_reg, quo_reg[rssg_pkg::QUO_W-1]};
    assign ge      = shifted >= {1'b0, iv_reg};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.prep) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
        end else if (cmd.step) begin
            quo_next = {quo_reg[rssg_pkg::QUO_W-2:0], ge};
            rem_next = ge ? 16'(shifted - {1'b0, iv_reg}) : shifted[15:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign status.div_last = (cnt_reg == rssg_pkg::CNT_W'(rssg_pkg::QUO_W - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    // Decision on the finished slot.
    always_comb begin
        act             = rssg_pkg::ACT_NONE;
        report          = rssg_pkg::NO_SLOT;
        handled_next    = handled_reg;
        sent_next       = sent_reg;
        light_tick_next = light_tick_reg;
        skip_pend_next  = skip_pend_reg;
        unique case (rssg_pkg::opcode_t'(item_reg.opcode))
            rssg_pkg::OP_POLL: begin
                if (!gate_en_reg || !item_reg.provisioned) begin
                    act = rssg_pkg::ACT_GATED;
                end else if (!slot_ok) begin
                    act = rssg_pkg::ACT_CLK_INVALID;
                end else begin
                    report = quo_reg;
                    priority if (quo_reg == handled_reg) begin
                        act = rssg_pkg::ACT_SAME_SLOT;
                    end else if (hold_reg) begin
                        act = rssg_pkg::ACT_HOLD;
                    end else if (skip_pend_reg && skip_hit_reg) begin
                        skip_pend_next = 1'b0;
                        handled_next   = quo_reg;
                        act            = rssg_pkg::ACT_SKIP_LIGHT;
                    end else begin
                        skip_pend_next = 1'b0;
                        priority if (quo_reg == sent_reg) begin
                            handled_next = quo_reg;
                            act          = rssg_pkg::ACT_SKIP_SENT;
                        end else if (item_reg.sampler_status != 2'd0) begin
                            act = item_reg.sampler_status[1] ? rssg_pkg::ACT_RESTART
                                                             : rssg_pkg::ACT_WAIT_FRAME;
                        end else begin
                            handled_next = quo_reg;
                            act          = rssg_pkg::ACT_SEND;
                        end
                    end
                end
            end
            rssg_pkg::OP_MARK: begin
                if (slot_ok) begin
                    sent_next = quo_reg;
                    report    = quo_reg;
                    act       = rssg_pkg::ACT_RECORDED;
                end else begin
                    act = rssg_pkg::ACT_CLK_INVALID;
                end
            end
            rssg_pkg::OP_LIGHT: begin
                light_tick_next = item_reg.now_ms;
                skip_pend_next  = 1'b1;
                act             = rssg_pkg::ACT_RECORDED;
            end
            rssg_pkg::OP_RESYNC: begin
                if (gate_en_reg) begin
                    handled_next = slot_ok ? quo_reg : rssg_pkg::NO_SLOT;
                    report       = handled_next;
                    act          = rssg_pkg::ACT_RECORDED;
                end else begin
                    handled_next = rssg_pkg::NO_SLOT;
                end
            end
            default: act = rssg_pkg::ACT_NONE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_en_reg    <= 1'b0;
            iv_reg         <= rssg_pkg::IV_DEFAULT;
            hold_ms_reg    <= '0;
            skip_ms_reg    <= '0;
            handled_reg    <= rssg_pkg::NO_SLOT;
            sent_reg       <= rssg_pkg::NO_SLOT;
            light_tick_reg <= '0;
            skip_pend_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_wen) begin
                unique case (rssg_pkg::reg_index_t'(cfg_index))
                    rssg_pkg::REG_GATE_ENABLE: gate_en_reg <= cfg_wdata[0];
                    rssg_pkg::REG_INTERVAL: begin
                        iv_reg <= (cfg_wdata[15:0] == 16'd0) ? rssg_pkg::IV_DEFAULT
                                                             : cfg_wdata[15:0];
                    end
                    rssg_pkg::REG_HOLD_MS: hold_ms_reg <= cfg_wdata;
                    rssg_pkg::REG_SKIP_MS: skip_ms_reg <= cfg_wdata;
                    default: gate_en_reg <= gate_en_reg;
                endcase
            end
            if (cmd.finish) begin
                handled_reg    <= handled_next;
                sent_reg       <= sent_next;
                light_tick_reg <= light_tick_next;
                skip_pend_reg  <= skip_pend_next;
            end
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.prep) begin
            hold_reg     <= hold_diff < hold_ms_reg;
            skip_hit_reg <= skip_diff <= skip_ms_reg;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.finish) begin
            out_reg.action     <= act;
            out_reg.slot_value <= report;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: sv/rssg_ctrl.sv
// Controller of the RTC slot snapshot gate: sequences capture, setup, divide
// and finish. Depends on rssg_pkg.
module rssg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output rssg_pkg::cmd_t    cmd,
    input  rssg_pkg::status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREP   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/rtc_slot_snapshot_gate_core.sv
// After an item is accepted, the setup state forms the second count and the tick compares,
// the divide state runs the radix-2 restoring divide by interval_seconds, and the finish
// state decides and loads the output register, waiting while that register is full and unread.
// The input is ready again the cycle after that; one item is in work at a time, and the
// next is accepted while a result still waits in the output register.
// Depends on rssg_pkg, rssg_ctrl and rssg_datapath.
module rtc_slot_snapshot_gate_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wen,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  rssg_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rssg_pkg::out_t m_data
);

    rssg_pkg::cmd_t    cmd;
    rssg_pkg::status_t status;

    rssg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    rssg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
